// ===== sv/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and sizes for the fixed-size block pool allocator.
// No dependencies; the controller, datapath, top level and checker refer to it by scoped names.
package fbfl_pkg;

	// Pool geometry.
	localparam int MAX_BLOCKS = 256;
	localparam int WORD_BYTES = 4;
	localparam int WORD_MASK  = WORD_BYTES - 1;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

	// Fixed field widths.
	localparam int ADDR_W   = 32;
	localparam int BSIZE_W  = 16;
	localparam int NBLK_W   = 9;
	localparam int USED_W   = 9;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CFGIDX_W = 2;
	localparam int PROD_W   = CNT_W + BSIZE_W;

	// Configuration register indexes.
	localparam logic [CFGIDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFGIDX_W-1:0] CFG_BSIZE = 2'd1;
	localparam logic [CFGIDX_W-1:0] CFG_NBLK  = 2'd2;

	localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
	localparam logic [BSIZE_W-1:0] BSIZE_RST = 16'd4;
	localparam logic [NBLK_W-1:0]  NBLK_RST  = 9'd256;

	// Command codes.
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADCFG  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   granted_address;
		logic [USED_W-1:0]   used_count;
	} rsp_t;

	// One link entry: next block index and whether there is a next block.
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] nxt;
	} link_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic set_badcfg;
		logic fill;
		logic init_end;
		logic set_nomem;
		logic alloc_rd;
		logic alloc_upd;
		logic free_chk;
		logic set_badfree;
		logic div_start;
		logic div_step;
		logic free_push;
		logic finish;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic cfg_bad;
		logic n_zero;
		logic fill_last;
		logic head_vld;
		logic range_bad;
		logic div_last;
		logic rem_nz;
	} sts_t;

endpackage

// ===== sv/fbfl_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// Standalone; used for the link store of the block pool.
module fbfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== sv/fbfl_ctrl.sv =====
`timescale 1ns / 1ps
// Command sequencer for the block pool allocator.
// Depends on fbfl_pkg for the command, status and code definitions.
module fbfl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbfl_pkg::FUNC_W-1:0]   func,
	input  fbfl_pkg::sts_t                sts,
	output fbfl_pkg::cmd_t                cmd,
	output logic                          busy,
	output logic                          done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_CHK,
		S_INIT_FILL,
		S_INIT_END,
		S_ALLOC_CHK,
		S_ALLOC_UPD,
		S_FREE_CHK,
		S_FREE_RANGE,
		S_FREE_DIV,
		S_FREE_END,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (func)
						fbfl_pkg::FUNC_INIT:  state_d = S_INIT_CHK;
						fbfl_pkg::FUNC_ALLOC: state_d = S_ALLOC_CHK;
						fbfl_pkg::FUNC_FREE:  state_d = S_FREE_CHK;
						default:              state_d = S_FINISH;
					endcase
				end
			end
			S_INIT_CHK: begin
				if (sts.cfg_bad) begin
					cmd.set_badcfg = 1'b1;
					state_d        = S_FINISH;
				end else if (sts.n_zero) begin
					state_d = S_INIT_END;
				end else begin
					state_d = S_INIT_FILL;
				end
			end
			S_INIT_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = S_INIT_END;
				end
			end
			S_INIT_END: begin
				cmd.init_end = 1'b1;
				state_d      = S_FINISH;
			end
			S_ALLOC_CHK: begin
				if (!sts.head_vld) begin
					cmd.set_nomem = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.alloc_rd = 1'b1;
					state_d      = S_ALLOC_UPD;
				end
			end
			S_ALLOC_UPD: begin
				cmd.alloc_upd = 1'b1;
				state_d       = S_FINISH;
			end
			S_FREE_CHK: begin
				cmd.free_chk = 1'b1;
				state_d      = S_FREE_RANGE;
			end
			S_FREE_RANGE: begin
				if (sts.range_bad) begin
					cmd.set_badfree = 1'b1;
					state_d         = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_FREE_DIV;
				end
			end
			S_FREE_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FREE_END;
				end
			end
			S_FREE_END: begin
				if (sts.rem_nz) begin
					cmd.set_badfree = 1'b1;
				end else begin
					cmd.free_push = 1'b1;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FINISH);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== sv/fbfl_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the block pool allocator: configuration, head, counter, divider, link store.
// Depends on fbfl_pkg and instantiates fbfl_ram.
module fbfl_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbfl_pkg::CFGIDX_W-1:0]   cfg_index,
	input  logic [fbfl_pkg::ADDR_W-1:0]     cfg_data,
	input  fbfl_pkg::req_t                  req,
	input  fbfl_pkg::cmd_t                  cmd,
	output fbfl_pkg::sts_t                  sts,
	output fbfl_pkg::rsp_t                  rsp
);

	logic [fbfl_pkg::ADDR_W-1:0]   base_q;
	logic [fbfl_pkg::BSIZE_W-1:0]  bsize_q;
	logic [fbfl_pkg::NBLK_W-1:0]   nblk_q;

	logic [fbfl_pkg::IDX_W-1:0]    head_q;
	logic                          head_vld_q;
	logic [fbfl_pkg::USED_W-1:0]   used_q;

	logic [fbfl_pkg::ADDR_W-1:0]   addr_q;
	logic [fbfl_pkg::STATUS_W-1:0] stat_q;
	logic [fbfl_pkg::ADDR_W-1:0]   grant_q;
	logic [fbfl_pkg::PROD_W-1:0]   prod_q;
	logic [fbfl_pkg::ADDR_W-1:0]   rem_q;
	logic [fbfl_pkg::IDX_W-1:0]    quo_q;
	logic [fbfl_pkg::CNT_W-1:0]    cnt_q;
	fbfl_pkg::rsp_t                rsp_q;

	logic [31:0]                   n_full;
	logic [fbfl_pkg::CNT_W-1:0]    n_blk;
	logic [fbfl_pkg::CNT_W-1:0]    cnt_inc;
	logic [fbfl_pkg::CNT_W-1:0]    mul_a;
	logic [fbfl_pkg::STEP_W-1:0]   step;
	logic [fbfl_pkg::ADDR_W-1:0]   trial;
	logic                          trial_fits;

	logic                          ram_en;
	logic                          ram_we;
	logic [fbfl_pkg::IDX_W-1:0]    ram_addr;
	fbfl_pkg::link_t               ram_wdata;
	logic [$bits(fbfl_pkg::link_t)-1:0] ram_rdata;
	fbfl_pkg::link_t               link_rd;

	// Effective pool size is the register capped at the store depth.
	assign n_full  = (32'(nblk_q) > 32'(fbfl_pkg::MAX_BLOCKS)) ?
		32'(fbfl_pkg::MAX_BLOCKS) : 32'(nblk_q);
	assign n_blk   = n_full[fbfl_pkg::CNT_W-1:0];
	assign cnt_inc = cnt_q + 1'b1;

	// One shared multiplier: head index times block size for alloc, pool size times
	// block size for the range check of free.
	assign mul_a = cmd.alloc_rd ? {1'b0, head_q} : n_blk;

	// Restoring division, one quotient bit per cycle, most significant first.
	assign step       = cnt_q[fbfl_pkg::STEP_W-1:0];
	assign trial      = 32'(bsize_q) << step;
	assign trial_fits = (rem_q >= trial);

	assign sts.cfg_bad   = (bsize_q == '0) ||
		((bsize_q & fbfl_pkg::BSIZE_W'(fbfl_pkg::WORD_MASK)) != '0) ||
		((base_q & fbfl_pkg::ADDR_W'(fbfl_pkg::WORD_MASK)) != '0);
	assign sts.n_zero    = (n_blk == '0);
	assign sts.fill_last = (cnt_inc == n_blk);
	assign sts.head_vld  = head_vld_q;
	assign sts.range_bad = (bsize_q == '0) || (64'(rem_q) >= 64'(prod_q));
	assign sts.div_last  = (cnt_q == '0);
	assign sts.rem_nz    = (rem_q != '0);

	always_comb begin
		ram_en    = cmd.fill | cmd.alloc_rd | cmd.free_push;
		ram_we    = cmd.fill | cmd.free_push;
		ram_addr  = head_q;
		ram_wdata = '{vld: head_vld_q, nxt: head_q};
		if (cmd.fill) begin
			ram_addr  = cnt_q[fbfl_pkg::IDX_W-1:0];
			ram_wdata = '{vld: (cnt_inc < n_blk), nxt: cnt_inc[fbfl_pkg::IDX_W-1:0]};
		end else if (cmd.free_push) begin
			ram_addr = quo_q;
		end
	end

	fbfl_ram #(
		.WIDTH($bits(fbfl_pkg::link_t)),
		.DEPTH(fbfl_pkg::MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign link_rd = fbfl_pkg::link_t'(ram_rdata);

	// Configuration and list state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= fbfl_pkg::BASE_RST;
			bsize_q    <= fbfl_pkg::BSIZE_RST;
			nblk_q     <= fbfl_pkg::NBLK_RST;
			head_q     <= '0;
			head_vld_q <= 1'b0;
			used_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fbfl_pkg::CFG_BASE:  base_q  <= cfg_data;
					fbfl_pkg::CFG_BSIZE: bsize_q <= cfg_data[fbfl_pkg::BSIZE_W-1:0];
					fbfl_pkg::CFG_NBLK:  nblk_q  <= cfg_data[fbfl_pkg::NBLK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.init_end) begin
				head_q     <= '0;
				head_vld_q <= (n_blk != '0);
				used_q     <= '0;
			end
			if (cmd.alloc_upd) begin
				head_q     <= link_rd.nxt;
				head_vld_q <= link_rd.vld;
				if (used_q != '1) begin
					used_q <= used_q + 1'b1;
				end
			end
			if (cmd.free_push) begin
				head_q     <= quo_q;
				head_vld_q <= 1'b1;
				if (used_q != '0) begin
					used_q <= used_q - 1'b1;
				end
			end
		end
	end

	// Per-command working registers and the result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= req.block_address;
			stat_q  <= fbfl_pkg::ST_OK;
			grant_q <= '0;
			cnt_q   <= '0;
		end
		if (cmd.fill) begin
			cnt_q <= cnt_inc;
		end
		if (cmd.set_badcfg) begin
			stat_q <= fbfl_pkg::ST_BADCFG;
		end
		if (cmd.set_nomem) begin
			stat_q <= fbfl_pkg::ST_NOMEM;
		end
		if (cmd.set_badfree) begin
			stat_q <= fbfl_pkg::ST_BADFREE;
		end
		if (cmd.alloc_rd || cmd.free_chk) begin
			prod_q <= fbfl_pkg::PROD_W'(mul_a) * fbfl_pkg::PROD_W'(bsize_q);
		end
		if (cmd.free_chk) begin
			rem_q <= addr_q - base_q;
		end
		if (cmd.alloc_upd) begin
			grant_q <= base_q + 32'(prod_q);
		end
		if (cmd.div_start) begin
			quo_q <= '0;
			cnt_q <= fbfl_pkg::CNT_W'(fbfl_pkg::IDX_W - 1);
		end
		if (cmd.div_step) begin
			if (trial_fits) begin
				rem_q       <= rem_q - trial;
				quo_q[step] <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.finish) begin
			rsp_q.status          <= stat_q;
			rsp_q.granted_address <= grant_q;
			rsp_q.used_count      <= used_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== sv/fixed_block_free_list_allocator_unit.sv =====
`timescale 1ns / 1ps
// Fixed-size block pool allocator with a last-in-first-out free list: top level.
// Depends on fbfl_pkg; instantiates fbfl_ctrl and fbfl_dp.
//
// A command word is taken when start is high and busy is low; its single result word
// appears on rsp for exactly one cycle with done high and cannot be held off, so the
// receiver must take it then. An alloc passes through its check and update states, or
// goes straight to the finish state when the list is empty. A free takes a range check
// and then an eight-step restoring divider that turns the byte offset into a block
// index; a free that fails the range check goes straight to the finish state. Init
// writes one link entry of the single-port link RAM per cycle for each pool block,
// and goes straight to the finish state when the geometry is rejected. Other codes
// also go straight to the finish state. A new command may be started in the cycle that done
// is shown. Configuration registers are written through cfg_we, cfg_index and cfg_data
// only while busy is low; the user is bound to this, the block itself does not enforce it.
module fixed_block_free_list_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fbfl_pkg::CFGIDX_W-1:0] cfg_index,
	input  logic [fbfl_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  fbfl_pkg::req_t                req,
	output logic                          done,
	output fbfl_pkg::rsp_t                rsp
);

	fbfl_pkg::cmd_t cmd;
	fbfl_pkg::sts_t sts;

	fbfl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (req.func),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	fbfl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

// ===== sv/fbfl_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the block pool allocator, bound to the top level.
// Depends on fbfl_pkg for the status codes.
module fbfl_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input fbfl_pkg::rsp_t rsp
);

	// An accepted word always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// A result only follows a busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// The strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A granted address is only given on success.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != fbfl_pkg::ST_OK) |-> (rsp.granted_address == '0))
		else $error("nonzero address with a failing status");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_chk u_fbfl_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

// ===== bench/fixed_block_free_list_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_block_free_list_allocator_unit: directed and random commands
// over several pool geometries, predicted by a scoreboard with its own copy of the free list.
// Depends on fbfl_pkg and the allocator RTL only.

import fbfl_pkg::*;

class pool_scoreboard;
	logic [ADDR_W-1:0]  base  = BASE_RST;
	logic [BSIZE_W-1:0] bsize = BSIZE_RST;
	logic [NBLK_W-1:0]  nblk  = NBLK_RST;

	logic [IDX_W-1:0] link_nxt [MAX_BLOCKS];
	logic             link_vld [MAX_BLOCKS];
	logic [IDX_W-1:0] head_idx = '0;
	logic             head_vld = 1'b0;
	logic [USED_W-1:0] used    = '0;

	rsp_t awaited [$];
	int   errors = 0;

	function void set_reg(logic [CFGIDX_W-1:0] idx, logic [ADDR_W-1:0] v);
		case (idx)
			CFG_BASE:  base  = v;
			CFG_BSIZE: bsize = v[BSIZE_W-1:0];
			CFG_NBLK:  nblk  = v[NBLK_W-1:0];
			default: ;
		endcase
	endfunction

	function int pool_count();
		return (nblk > NBLK_W'(MAX_BLOCKS)) ? MAX_BLOCKS : int'(nblk);
	endfunction

	// Applies one command to the shadow pool and returns the word it should produce.
	function rsp_t pool_step(req_t w);
		rsp_t r;
		int n;
		logic [ADDR_W-1:0] off;
		logic [ADDR_W-1:0] idx;
		r.status = ST_OK;
		r.granted_address = '0;
		n = pool_count();
		case (w.func)
			FUNC_INIT: begin
				if (bsize == 0 || (bsize & BSIZE_W'(WORD_MASK)) != 0 ||
				    (base & ADDR_W'(WORD_MASK)) != 0) begin
					r.status = ST_BADCFG;
				end else begin
					for (int i = 0; i < n; i++) begin
						link_nxt[i] = IDX_W'(i + 1);
						link_vld[i] = (i + 1) < n;
					end
					head_idx = '0;
					head_vld = n > 0;
					used = '0;
				end
			end
			FUNC_ALLOC: begin
				if (!head_vld) begin
					r.status = ST_NOMEM;
				end else begin
					r.granted_address = base + ADDR_W'(head_idx) * ADDR_W'(bsize);
					idx = ADDR_W'(head_idx);
					head_vld = link_vld[idx];
					head_idx = link_nxt[idx];
					if (used != '1)
						used++;
				end
			end
			FUNC_FREE: begin
				off = w.block_address - base;
				if (bsize == 0 || (off % ADDR_W'(bsize)) != 0) begin
					r.status = ST_BADFREE;
				end else begin
					idx = off / ADDR_W'(bsize);
					if (idx >= ADDR_W'(n)) begin
						r.status = ST_BADFREE;
					end else begin
						link_nxt[idx] = head_idx;
						link_vld[idx] = head_vld;
						head_idx = idx[IDX_W-1:0];
						head_vld = 1'b1;
						if (used != 0)
							used--;
					end
				end
			end
			default: ;
		endcase
		r.used_count = used;
		return r;
	endfunction

	function rsp_t note_word(req_t w);
		rsp_t r;
		r = pool_step(w);
		awaited.push_back(r);
		return r;
	endfunction

	function void check_word(rsp_t got);
		rsp_t want;
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: result word with none expected: status %0d addr %h used %0d",
				$time, got.status, got.granted_address, got.used_count);
			return;
		end
		want = awaited.pop_front();
		if (got.status !== want.status) begin
			errors++;
			$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
		end
		if (got.granted_address !== want.granted_address) begin
			errors++;
			$display("%0t: granted_address expected %h got %h", $time,
				want.granted_address, got.granted_address);
		end
		if (got.used_count !== want.used_count) begin
			errors++;
			$display("%0t: used_count expected %0d got %0d", $time,
				want.used_count, got.used_count);
		end
	endfunction
endclass

module fixed_block_free_list_allocator_unit_test;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFGIDX_W-1:0] cfg_index = CFG_BASE;
	logic [ADDR_W-1:0]   cfg_data = '0;
	logic                start = 1'b0;
	logic                busy;
	req_t                req = '0;
	logic                done;
	rsp_t                rsp;

	pool_scoreboard sb = new;
	logic [ADDR_W-1:0] live_blocks [$];

	fixed_block_free_list_allocator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_word(rsp);
	end

	initial begin
		#10_000_000;
		$display("fixed_block_free_list_allocator_unit_test: done, errors");
		$finish;
	end

	function automatic req_t cmd(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
		req_t w;
		w.func = f;
		w.block_address = a;
		return w;
	endfunction

	task automatic send_word(input req_t w);
		rsp_t guess;
		logic taken;
		@(negedge clk);
		start <= 1'b1;
		req <= w;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		guess = sb.note_word(w);
		if (w.func == FUNC_ALLOC && guess.status == ST_OK)
			live_blocks.push_back(guess.granted_address);
		if (w.func == FUNC_INIT && guess.status == ST_OK)
			live_blocks.delete();
	endtask

	task automatic pause_gap(input int pct);
		int n;
		if (pct > 0 && $urandom_range(99) < pct) begin
			@(negedge clk) start <= 1'b0;
			n = 1;
			while (n < 40 && $urandom_range(99) < pct) begin
				@(negedge clk);
				n++;
			end
		end
	endtask

	// Holds off new words until every expected result is back and the block is idle.
	task automatic drain();
		@(negedge clk) start <= 1'b0;
		while (sb.awaited.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input logic [ADDR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Allocs and frees; frees mostly of loaned blocks, some stray or repeated.
	function automatic req_t pick_word();
		req_t w;
		int r;
		int s;
		int k;
		r = $urandom_range(99);
		w.block_address = $urandom;
		if (r < 46) begin
			w.func = FUNC_ALLOC;
		end else if (r < 90) begin
			w.func = FUNC_FREE;
			s = $urandom_range(99);
			if (s < 65 && live_blocks.size() > 0) begin
				k = $urandom_range(live_blocks.size() - 1);
				w.block_address = live_blocks[k];
				live_blocks.delete(k);
			end else if (s < 85) begin
				w.block_address = sb.base +
					ADDR_W'($urandom_range(sb.pool_count())) * ADDR_W'(sb.bsize);
			end else begin
				case ($urandom_range(2))
					0: ;
					1: w.block_address = sb.base +
						ADDR_W'($urandom_range(sb.pool_count())) * ADDR_W'(sb.bsize) +
						ADDR_W'($urandom_range(1, 3));
					default: w.block_address = sb.base - ADDR_W'(sb.bsize);
				endcase
			end
		end else if (r < 96) begin
			w.func = FUNC_INIT;
		end else begin
			w.func = FUNC_NONE;
		end
		return w;
	endfunction

	task automatic load_phase(input int p, output int idle, output int count);
		logic [ADDR_W-1:0] aligned;
		aligned = $urandom & ~ADDR_W'(WORD_MASK);
		case (p)
			0: begin
				write_reg(CFG_BASE, aligned);
				write_reg(CFG_BSIZE, ADDR_W'(4 * $urandom_range(1, 8)));
				write_reg(CFG_NBLK, ADDR_W'($urandom_range(2, 12)));
				idle = 21; count = 110;
			end
			1: begin
				// Top of the address space: block addresses wrap past zero.
				write_reg(CFG_BASE, 32'hFFFF_FFFC);
				write_reg(CFG_BSIZE, 32'h0000_FFFC);
				write_reg(CFG_NBLK, 32'd256);
				idle = 21; count = 90;
			end
			2: begin
				write_reg(CFG_BASE, 32'd0);
				write_reg(CFG_BSIZE, 32'd4);
				write_reg(CFG_NBLK, 32'd1);
				idle = 88; count = 70;
			end
			3: begin
				write_reg(CFG_BASE, aligned);
				write_reg(CFG_BSIZE, ADDR_W'(4 * $urandom_range(1, 16383)));
				write_reg(CFG_NBLK, ADDR_W'($urandom_range(1, 256)));
				idle = 88; count = 90;
			end
			4: begin
				write_reg(CFG_BASE, aligned);
				write_reg(CFG_BSIZE, 32'd8);
				write_reg(CFG_NBLK, 32'd0);
				idle = 0; count = 50;
			end
			5: begin
				// A count above the pool limit is clamped to the full pool.
				write_reg(CFG_BASE, aligned);
				write_reg(CFG_BSIZE, 32'd12);
				write_reg(CFG_NBLK, 32'h1FF);
				idle = 0; count = 90;
			end
			6: begin
				// Odd block size: init is refused and the old list stays in use.
				write_reg(CFG_BSIZE, 32'h0000_FFFF);
				write_reg(CFG_NBLK, 32'd5);
				idle = 0; count = 60;
			end
			7: begin
				write_reg(CFG_BASE, $urandom | 32'd2);
				write_reg(CFG_BSIZE, 32'd8);
				write_reg(CFG_NBLK, 32'd8);
				idle = 0; count = 50;
			end
			default: begin
				write_reg(CFG_BASE, aligned);
				write_reg(CFG_BSIZE, ADDR_W'(4 * $urandom_range(1, 32)));
				write_reg(CFG_NBLK, ADDR_W'($urandom_range(1, 64)));
				idle = 0; count = 100;
			end
		endcase
	endtask

	initial begin
		int idle;
		int count;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		write_reg(CFG_BASE, 32'h0000_1000);
		write_reg(CFG_BSIZE, 32'd16);
		write_reg(CFG_NBLK, 32'd4);
		// Before any init the list is empty; a free still pushes and the count stays at zero.
		send_word(cmd(FUNC_ALLOC, '0));
		send_word(cmd(FUNC_FREE, 32'h0000_1010));
		send_word(cmd(FUNC_ALLOC, '1));
		send_word(cmd(FUNC_INIT, '0));
		repeat (5) send_word(cmd(FUNC_ALLOC, '0));
		send_word(cmd(FUNC_FREE, 32'h0000_1001));
		send_word(cmd(FUNC_FREE, 32'h0000_1040));
		send_word(cmd(FUNC_FREE, 32'h0000_0FF0));
		send_word(cmd(FUNC_FREE, '1));
		send_word(cmd(FUNC_FREE, '0));
		// Double free puts the same block on the list twice.
		send_word(cmd(FUNC_FREE, 32'h0000_1020));
		send_word(cmd(FUNC_FREE, 32'h0000_1020));
		send_word(cmd(FUNC_ALLOC, '0));
		send_word(cmd(FUNC_ALLOC, '0));
		send_word(cmd(FUNC_NONE, '1));
		drain();
		write_reg(CFG_BSIZE, 32'd0);
		send_word(cmd(FUNC_INIT, '0));
		send_word(cmd(FUNC_FREE, 32'h0000_1000));
		drain();
		write_reg(CFG_BSIZE, 32'd6);
		send_word(cmd(FUNC_INIT, '0));
		send_word(cmd(FUNC_FREE, 32'h0000_100C));
		drain();
		write_reg(CFG_BSIZE, 32'd16);
		write_reg(CFG_BASE, 32'h0000_1002);
		send_word(cmd(FUNC_INIT, '0));
		send_word(cmd(FUNC_ALLOC, '0));

		for (int p = 0; p < 9; p++) begin
			drain();
			load_phase(p, idle, count);
			send_word(cmd(FUNC_INIT, $urandom));
			repeat (count) begin
				pause_gap(idle);
				if ($urandom_range(199) == 0)
					drain();
				send_word(pick_word());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("fixed_block_free_list_allocator_unit_test: done, clean");
		end else begin
			$display("fixed_block_free_list_allocator_unit_test: done, errors");
		end
		$finish;
	end
endmodule
